// ===== hdl/pqs_pkg.sv =====
// Shared types and constants of the periodic query scheduler.
package pqs_pkg;

   localparam int unsigned TIME_FIELD_BITS   = 53;
   localparam int unsigned PERIOD_FIELD_BITS = 48;
   localparam int unsigned COUNT_FIELD_BITS  = 17;
   localparam int unsigned CSR_DATA_BITS     = 53;
   localparam int unsigned CSR_INDEX_BITS    = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FIRST_TIME   = 3'd0,
      CSR_LAST_TIME    = 3'd1,
      CSR_RUN_PERIOD   = 3'd2,
      CSR_SEND_COUNT   = 3'd3,
      CSR_SEND_ENABLE  = 3'd4,
      CSR_CLEAR_ENABLE = 3'd5,
      CSR_RECEIVE_WAIT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [TIME_FIELD_BITS-1:0]   first_time;
      logic [TIME_FIELD_BITS-1:0]   last_time;
      logic [PERIOD_FIELD_BITS-1:0] run_period;
      logic                         send_enable;
      logic                         clear_enable;
      logic                         receive_wait;
   } cfg_type;

   // Reload of the remaining count on a send_count write.
   typedef struct packed {
      logic                        load;
      logic                        unlimited;
      logic [COUNT_FIELD_BITS-2:0] count;
   } count_load_type;

   typedef struct packed {
      logic [TIME_FIELD_BITS-1:0] time_now;
      logic                       srq_pending;
      logic                       srq_request;
      logic                       data_available;
   } req_item_type;

   typedef struct packed {
      logic do_send;
      logic do_clear;
      logic do_receive;
      logic keep_going;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } result_type;

   typedef struct packed {
      logic can_take;
   } out_status_type;

endpackage

// ===== hdl/pqs_if.sv =====
// Channel interfaces: request, response and register write.
interface pqs_req_if import pqs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [TIME_FIELD_BITS-1:0] time_now;
   logic                       srq_pending;
   logic                       srq_request;
   logic                       data_available;

   modport source (output valid, time_now, srq_pending, srq_request, data_available,
                   input ready);
   modport sink   (input valid, time_now, srq_pending, srq_request, data_available,
                   output ready);
endinterface

interface pqs_rsp_if import pqs_pkg::*; ();
   logic valid;
   logic ready;
   logic do_send;
   logic do_clear;
   logic do_receive;
   logic keep_going;

   modport source (output valid, do_send, do_clear, do_receive, keep_going, input ready);
   modport sink   (input valid, do_send, do_clear, do_receive, keep_going, output ready);
endinterface

interface pqs_csr_if import pqs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pqs_csr.sv =====
// Configuration register file and count reload decode.
module pqs_csr import pqs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                   cfg,
   output count_load_type            count_load
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    count_write;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in      = cfg_ff;
      count_write = 1'b0;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIRST_TIME:   cfg_in.first_time   = TIME_FIELD_BITS'(csr_data);
            CSR_LAST_TIME:    cfg_in.last_time    = TIME_FIELD_BITS'(csr_data);
            CSR_RUN_PERIOD:   cfg_in.run_period   = PERIOD_FIELD_BITS'(csr_data);
            CSR_SEND_COUNT:   count_write         = 1'b1;
            CSR_SEND_ENABLE:  cfg_in.send_enable  = csr_data[0];
            CSR_CLEAR_ENABLE: cfg_in.clear_enable = csr_data[0];
            CSR_RECEIVE_WAIT: cfg_in.receive_wait = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg                  = cfg_ff;
   assign count_load.load      = count_write;
   assign count_load.unlimited = csr_data[COUNT_FIELD_BITS-1];
   assign count_load.count     = csr_data[COUNT_FIELD_BITS-2:0];

endmodule

// ===== hdl/pqs_core.sv =====
// Input register, run decision and scheduler state update.
module pqs_core import pqs_pkg::*; #(
   parameter int unsigned TIME_BITS  = 53,
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_item_type   req_item,
   input  cfg_type        cfg,
   input  count_load_type count_load,
   input  out_status_type out_status,
   output result_type     result
);

   localparam int unsigned T = TIME_BITS;
   localparam logic [T-1:0] TIME_MAX = '1;
   localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

   logic                  in_valid_ff, in_valid_in;
   req_item_type          in_item_ff;
   logic [T-1:0]          next_run_ff, next_run_in;
   logic                  unlim_ff, unlim_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;

   logic                  advance;
   logic [T-1:0]          now, first, last, period, armed_run, base;
   logic [T:0]            sum;
   logic                  timed_fire, fire_req, fire;
   logic [31:0]           load_wide;
   logic [COUNT_BITS-1:0] rem_load;

   assign advance   = in_valid_ff && out_status.can_take;
   assign req_ready = !in_valid_ff || out_status.can_take;

   assign now    = T'(in_item_ff.time_now);
   assign first  = T'(cfg.first_time);
   assign last   = T'(cfg.last_time);
   assign period = T'(cfg.run_period);

   // Saturate the reloaded count to the counter range.
   assign load_wide = 32'(count_load.count);
   assign rem_load  = (load_wide > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                              : COUNT_BITS'(load_wide);

   always_comb begin
      armed_run  = next_run_ff;
      timed_fire = 1'b0;
      if (next_run_ff == '0 && first < now) begin
         armed_run = (first == '0) ? now : first;
      end else if (next_run_ff != '0 && next_run_ff < now) begin
         timed_fire = !in_item_ff.srq_pending && !(last != '0 && now > last);
      end
      fire_req = timed_fire || in_item_ff.srq_request;

      // Count down finite budgets; an empty budget cancels the run.
      fire   = fire_req;
      rem_in = rem_ff;
      if (fire_req && !unlim_ff) begin
         if (rem_ff == '0) begin
            fire = 1'b0;
         end else begin
            rem_in = rem_ff - COUNT_BITS'(1);
         end
      end

      // Advance the run time, saturating at the top of the time range.
      base        = (armed_run == '0) ? now : armed_run;
      sum         = {1'b0, base} + {1'b0, period};
      next_run_in = armed_run;
      if (fire && period != '0) begin
         next_run_in = sum[T] ? TIME_MAX : sum[T-1:0];
      end

      unlim_in = unlim_ff;

      result.valid           = advance;
      result.item.do_send    = fire && cfg.send_enable;
      result.item.do_clear   = fire && cfg.clear_enable;
      result.item.do_receive = fire && cfg.receive_wait
                               && (cfg.send_enable || in_item_ff.data_available);
      result.item.keep_going = (last != '0) ? (last > now) : (unlim_ff || rem_in != '0);
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         next_run_ff <= '0;
         unlim_ff    <= 1'b1;
         rem_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            next_run_ff <= next_run_in;
         end
         if (count_load.load) begin
            unlim_ff <= count_load.unlimited;
            rem_ff   <= rem_load;
         end else if (advance) begin
            unlim_ff <= unlim_in;
            rem_ff   <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

endmodule

// ===== hdl/pqs_out.sv =====
// Two-entry result buffer in front of the response channel.
module pqs_out import pqs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  result_type     result,
   output out_status_type out_status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_item_type   rsp_item
);

   rsp_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = result.valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (result.valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!result.valid && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         slot_ff[wr_ptr_ff] <= result.item;
      end
   end

   assign out_status.can_take = (count_ff != 2'd2);
   assign rsp_valid           = (count_ff != 2'd0);
   assign rsp_item            = slot_ff[rd_ptr_ff];

endmodule

// ===== hdl/periodic_query_scheduler_unit.sv =====
// Top level of the periodic query scheduler.
// One request item is one tick carrying the current time in microseconds; each
// tick yields exactly one response item with the send, clear and receive
// actions and the keep-going flag. The block takes one item per clock cycle
// while the result buffer has room. The item sits in an input register, the
// run decision, count update and saturating run-time add are combinational,
// and the result enters a two-entry buffer that feeds the response channel.
// Req ready is set by the input register and the buffer fill only, so a
// stalled response side never feeds back combinationally into the request
// side. Register writes are taken in any cycle with csr ready held high;
// writes must only occur while no item is in flight. A send_count write
// reloads the remaining count at once.
module periodic_query_scheduler_unit import pqs_pkg::*; #(
   parameter int unsigned TIME_BITS  = 53,
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   pqs_req_if.sink    req_ch,
   pqs_rsp_if.source  rsp_ch,
   pqs_csr_if.sink    csr_ch
);

   cfg_type        cfg;
   count_load_type count_load;
   req_item_type   req_item;
   result_type     result;
   out_status_type out_status;
   rsp_item_type   rsp_item;

   // Gather the request fields into one item.
   assign req_item.time_now       = req_ch.time_now;
   assign req_item.srq_pending    = req_ch.srq_pending;
   assign req_item.srq_request    = req_ch.srq_request;
   assign req_item.data_available = req_ch.data_available;

   pqs_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_ch.valid),
      .csr_ready  (csr_ch.ready),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data),
      .cfg        (cfg),
      .count_load (count_load)
   );

   pqs_core #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_item   (req_item),
      .cfg        (cfg),
      .count_load (count_load),
      .out_status (out_status),
      .result     (result)
   );

   pqs_out u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_status (out_status),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_item   (rsp_item)
   );

   // Spread the result item onto the response channel.
   assign rsp_ch.do_send    = rsp_item.do_send;
   assign rsp_ch.do_clear   = rsp_item.do_clear;
   assign rsp_ch.do_receive = rsp_item.do_receive;
   assign rsp_ch.keep_going = rsp_item.keep_going;

   // A send action only appears while the query has a message.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.do_send |-> cfg.send_enable)
      else $error("send action without send_enable");

   // A receive action only appears while a reply is expected.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.do_receive |-> cfg.receive_wait)
      else $error("receive action without receive_wait");

   // The core never hands over a result the buffer cannot hold.
   assert property (@(posedge clock) disable iff (reset)
      result.valid |-> out_status.can_take)
      else $error("result written into a full buffer");

   // Reset empties the result buffer.
   assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

endmodule

// ===== tb/sv/periodic_query_scheduler_unit_test.sv =====
// Self-checking testbench of the periodic query scheduler: directed and random ticks.
module periodic_query_scheduler_unit_test;
   import pqs_pkg::*;

   localparam int unsigned TIME_BITS   = 53;
   localparam int unsigned COUNT_BITS  = 16;
   localparam int          COUNT_UNLIMITED = -1;
   localparam int          COUNT_MAX   = (1 << COUNT_BITS) - 1;
   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned PRINT_LIMIT = 40;
   localparam int unsigned TICK_TARGET = 1130;
   localparam logic [TIME_FIELD_BITS-1:0]   TIME_MAX   = '1;
   localparam logic [PERIOD_FIELD_BITS-1:0] PERIOD_MAX = '1;
   // Index that maps to no register; a write to it must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0]    CSR_INDEX_UNUSED = 3'd7;

   typedef enum int {OPEN_ARM_NOW, OPEN_ARM_FIRST, OPEN_FORCED} opening_kind_type;
   typedef enum int {RSP_FLOW, RSP_COIN, RSP_SPARSE, RSP_PULSE} rsp_pattern_type;

   logic clock = 1'b0;
   logic reset;

   pqs_req_if req_bus ();
   pqs_rsp_if rsp_bus ();
   pqs_csr_if csr_bus ();

   periodic_query_scheduler_unit #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Scheduler shadow: register copy, next run time and remaining run count.
   cfg_type                    sched_cfg       = '0;
   logic [TIME_FIELD_BITS-1:0] sched_next_run  = '0;
   int                         sched_remaining = COUNT_UNLIMITED;

   // Actions expected from the block, oldest first.
   rsp_item_type pending_actions[$];

   int unsigned mismatch_count = 0;
   int unsigned results_seen   = 0;
   int unsigned ticks_sent     = 0;
   int unsigned cycle_count    = 0;
   int unsigned burst_left     = 0;
   // Latest time of the orderly timeline; phases continue from here.
   logic [TIME_FIELD_BITS-1:0] world_time = '0;

   // Work out the actions of one tick and advance the shadow state.
   function automatic rsp_item_type advance_schedule(req_item_type tick);
      logic [TIME_FIELD_BITS-1:0] now;
      logic [TIME_FIELD_BITS-1:0] base;
      logic [TIME_FIELD_BITS:0]   sum;
      logic                       fire;
      logic                       keep;
      rsp_item_type               action;
      now  = tick.time_now;
      fire = 1'b0;
      // Arm on the first tick past first_time; otherwise fire once the run time has passed.
      if (sched_next_run == '0 && sched_cfg.first_time < now) begin
         sched_next_run = (sched_cfg.first_time == '0) ? now : sched_cfg.first_time;
      end else if (sched_next_run != '0 && sched_next_run < now) begin
         fire = !tick.srq_pending;
         if (sched_cfg.last_time != '0 && now > sched_cfg.last_time) begin
            fire = 1'b0;
         end
      end
      // A service request forces a run, still subject to the count.
      if (tick.srq_request) begin
         fire = 1'b1;
      end
      if (fire && sched_remaining >= 0) begin
         if (sched_remaining == 0) begin
            fire = 1'b0;
         end else begin
            sched_remaining--;
         end
      end
      // Advance the run time by the period; an unarmed block starts from now. Saturate.
      if (fire && sched_cfg.run_period != '0) begin
         base = (sched_next_run == '0) ? now : sched_next_run;
         sum  = {1'b0, base} +
                {{(TIME_FIELD_BITS - PERIOD_FIELD_BITS + 1){1'b0}}, sched_cfg.run_period};
         sched_next_run = sum[TIME_FIELD_BITS] ? TIME_MAX : sum[TIME_FIELD_BITS-1:0];
      end
      keep = (sched_cfg.last_time != '0) ? (sched_cfg.last_time > now)
                                         : (sched_remaining != 0);
      action.do_send    = fire & sched_cfg.send_enable;
      action.do_clear   = fire & sched_cfg.clear_enable;
      action.do_receive = fire & sched_cfg.receive_wait &
                          (sched_cfg.send_enable | tick.data_available);
      action.keep_going = keep;
      return action;
   endfunction

   function automatic logic [TIME_FIELD_BITS-1:0] rand_time();
      logic [63:0] word;
      word = {$urandom, $urandom};
      return word[TIME_FIELD_BITS-1:0];
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      // Cap the log; every mismatch still counts.
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("ERROR t=%0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(string name, logic got, logic want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got %b, expected %b",
                                   results_seen, name, got, want));
      end
   endtask

   // Write one register and mirror it into the shadow. Leave csr valid high;
   // the caller drops it after the last write of a group.
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_FIRST_TIME:   sched_cfg.first_time   = value[TIME_FIELD_BITS-1:0];
         CSR_LAST_TIME:    sched_cfg.last_time    = value[TIME_FIELD_BITS-1:0];
         CSR_RUN_PERIOD:   sched_cfg.run_period   = value[PERIOD_FIELD_BITS-1:0];
         CSR_SEND_COUNT: begin
            // Negative means unlimited; writing reloads the remaining count.
            if (value[COUNT_FIELD_BITS-1]) begin
               sched_remaining = COUNT_UNLIMITED;
            end else if (value[COUNT_FIELD_BITS-2:0] > COUNT_MAX) begin
               sched_remaining = COUNT_MAX;
            end else begin
               sched_remaining = int'(value[COUNT_FIELD_BITS-2:0]);
            end
         end
         CSR_SEND_ENABLE:  sched_cfg.send_enable  = value[0];
         CSR_CLEAR_ENABLE: sched_cfg.clear_enable = value[0];
         CSR_RECEIVE_WAIT: sched_cfg.receive_wait = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Send one tick; record its expected actions at acceptance. Return at a falling
   // edge, with valid still high inside a burst; between bursts valid may drop for a gap.
   task automatic send_tick(logic [TIME_FIELD_BITS-1:0] now, logic pending, logic request,
                            logic avail);
      req_item_type tick;
      int unsigned  gap;
      tick.time_now       = now;
      tick.srq_pending    = pending;
      tick.srq_request    = request;
      tick.data_available = avail;
      req_bus.valid          = 1'b1;
      req_bus.time_now       = now;
      req_bus.srq_pending    = pending;
      req_bus.srq_request    = request;
      req_bus.data_available = avail;
      do @(posedge clock); while (!req_bus.ready);
      pending_actions.push_back(advance_schedule(tick));
      ticks_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Hold off the sender, drain every expected action and let the pipe settle.
   task automatic settle_block();
      req_bus.valid = 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Right after reset the block is unarmed; take one of the three ways out of it.
   task automatic test_opening();
      opening_kind_type           kind;
      logic [TIME_FIELD_BITS-1:0] first;
      logic [TIME_FIELD_BITS-1:0] now;
      kind  = opening_kind_type'($urandom_range(0, 2));
      first = (kind == OPEN_ARM_NOW) ? '0 : TIME_FIELD_BITS'($urandom_range(1, 1000));
      write_reg(CSR_FIRST_TIME, first);
      write_reg(CSR_RUN_PERIOD, 10);
      write_reg(CSR_SEND_ENABLE, 1);
      write_reg(CSR_RECEIVE_WAIT, 1);
      csr_bus.valid = 1'b0;
      case (kind)
         OPEN_ARM_NOW: begin
            // Time zero does not arm; the next tick arms at its own time.
            send_tick(0, 0, 0, 0);
            send_tick(5, 0, 0, 1);
            send_tick(5, 0, 0, 0);
            now = 6;
            send_tick(now, 0, 0, 1);
         end
         OPEN_ARM_FIRST: begin
            send_tick(first, 0, 0, 0);
            send_tick(first + 7, 0, 0, 1);
            now = first + 8;
            send_tick(now, 0, 0, 0);
         end
         default: begin
            // Forced run while unarmed: run time becomes now plus period.
            now = $urandom_range(0, first);
            send_tick(now, 0, 1, 1);
            now = now + 11;
            send_tick(now, 0, 0, 0);
         end
      endcase
      world_time = now;
   endtask

   // Suppression, forced runs, counts, stop time and the time extremes.
   task automatic test_special_cases();
      logic [TIME_FIELD_BITS-1:0] b;
      settle_block();
      b = sched_next_run;
      write_reg(CSR_INDEX_UNUSED, rand_time());
      write_reg(CSR_RUN_PERIOD, 10);
      write_reg(CSR_SEND_COUNT, 53'h1_0000);     // negative, taken as unlimited
      write_reg(CSR_LAST_TIME, 0);
      write_reg(CSR_SEND_ENABLE, 1);
      write_reg(CSR_CLEAR_ENABLE, 1);
      write_reg(CSR_RECEIVE_WAIT, 1);
      write_reg(CSR_FIRST_TIME, TIME_MAX);
      csr_bus.valid = 1'b0;
      send_tick(b + 1, 0, 0, 0);                 // timed run
      send_tick(b + 20, 1, 0, 0);                // pending service request holds it off
      send_tick(b + 20, 1, 1, 0);                // service request forces it
      send_tick(0, 0, 0, 1);                     // earliest time
      send_tick(TIME_MAX, 0, 0, 0);              // latest time
      settle_block();
      write_reg(CSR_SEND_COUNT, 53'h2_0002);     // upper bits ignored: two runs
      write_reg(CSR_SEND_ENABLE, 0);
      write_reg(CSR_LAST_TIME, b + 100);
      csr_bus.valid = 1'b0;
      send_tick(b + 40, 0, 0, 0);                // clear only, nothing to read
      send_tick(b + 50, 0, 0, 1);                // read because data is waiting
      send_tick(b + 60, 0, 0, 1);                // count used up
      send_tick(b + 60, 0, 1, 1);                // even a forced run is cancelled
      settle_block();
      write_reg(CSR_SEND_COUNT, COUNT_MAX);
      write_reg(CSR_LAST_TIME, b + 65);
      csr_bus.valid = 1'b0;
      send_tick(b + 70, 0, 0, 0);                // past the stop time
      send_tick(b + 70, 0, 1, 1);                // forced run ignores the stop time
      settle_block();
      write_reg(CSR_LAST_TIME, 0);
      write_reg(CSR_SEND_COUNT, 0);
      csr_bus.valid = 1'b0;
      send_tick(b + 80, 0, 0, 0);                // zero count: no run, not going
      settle_block();
      write_reg(CSR_SEND_COUNT, 53'h1_FFFF);
      write_reg(CSR_RUN_PERIOD, 0);
      csr_bus.valid = 1'b0;
      send_tick(b + 100, 0, 0, 1);               // zero period: run time stays
      send_tick(b + 100, 0, 0, 0);
      world_time = b + 100;
   endtask

   // Orderly timeline: time moves forward around the period, random settings.
   task automatic test_timeline(int unsigned n);
      logic [TIME_FIELD_BITS-1:0]   now;
      logic [TIME_FIELD_BITS-1:0]   stop;
      logic [PERIOD_FIELD_BITS-1:0] period;
      logic [CSR_DATA_BITS-1:0]     count_word;
      int unsigned                  span;
      int unsigned                  step_max;
      settle_block();
      case ($urandom_range(0, 9))
         0:       period = '0;
         1, 2:    period = $urandom_range(1, 100_000);
         default: period = $urandom_range(1, 200);
      endcase
      now      = (world_time > sched_next_run) ? world_time : sched_next_run;
      step_max = (period == '0) ? 20 : 2 * int'(period);
      span     = step_max / 2 * n;
      case ($urandom_range(0, 5))
         0, 1:    stop = '0;
         2, 3:    stop = now + $urandom_range(0, span);
         4:       stop = rand_time();
         default: stop = $urandom_range(1, 1000);
      endcase
      count_word = rand_time();
      case ($urandom_range(0, 3))
         0: count_word[COUNT_FIELD_BITS-1] = 1'b1;
         1: begin
            count_word[COUNT_FIELD_BITS-1] = 1'b0;
            count_word[COUNT_FIELD_BITS-2:0] = $urandom_range(0, n / 2);
         end
         default: count_word[COUNT_FIELD_BITS-1] = 1'b0;
      endcase
      write_reg(CSR_RUN_PERIOD, period);
      write_reg(CSR_LAST_TIME, stop);
      if ($urandom_range(0, 3) != 0) write_reg(CSR_SEND_COUNT, count_word);
      if ($urandom_range(0, 1) != 0) write_reg(CSR_FIRST_TIME, rand_time());
      if ($urandom_range(0, 3) != 0) write_reg(CSR_SEND_ENABLE, rand_time());
      if ($urandom_range(0, 3) != 0) write_reg(CSR_CLEAR_ENABLE, rand_time());
      if ($urandom_range(0, 3) != 0) write_reg(CSR_RECEIVE_WAIT, rand_time());
      if ($urandom_range(0, 7) == 0) write_reg(CSR_INDEX_UNUSED, rand_time());
      csr_bus.valid = 1'b0;
      repeat (n) begin
         now = now + $urandom_range(0, step_max);
         send_tick(now, $urandom_range(0, 5) == 0, $urandom_range(0, 9) == 0,
                   $urandom_range(0, 1));
      end
      world_time = now;
   endtask

   // Disorderly ticks: random and backward times, random flags. Wide mode also
   // spans the full register ranges.
   task automatic test_noise(int unsigned n, bit wide);
      logic [TIME_FIELD_BITS-1:0] now;
      logic [TIME_FIELD_BITS-1:0] word;
      settle_block();
      word = rand_time();
      write_reg(CSR_RUN_PERIOD, wide ? word[PERIOD_FIELD_BITS-1:0]
                                     : PERIOD_FIELD_BITS'($urandom_range(0, 1 << 20)));
      write_reg(CSR_LAST_TIME, ($urandom_range(0, 1) != 0) ? rand_time() : '0);
      write_reg(CSR_SEND_COUNT, rand_time());
      write_reg(CSR_SEND_ENABLE, rand_time());
      write_reg(CSR_CLEAR_ENABLE, rand_time());
      write_reg(CSR_RECEIVE_WAIT, rand_time());
      csr_bus.valid = 1'b0;
      repeat (n) begin
         case ($urandom_range(0, 4))
            0:       now = rand_time();
            1:       now = (world_time > 5000) ? world_time - $urandom_range(0, 5000) : '0;
            2:       now = ($urandom_range(0, 1) != 0) ? TIME_MAX : '0;
            default: now = world_time + $urandom_range(0, 5000);
         endcase
         send_tick(now, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      end
   endtask

   // Push the run time to the top of the range; afterwards only requests run.
   task automatic test_run_time_saturation();
      settle_block();
      write_reg(CSR_RUN_PERIOD, PERIOD_MAX);
      write_reg(CSR_SEND_COUNT, 53'h1_FFFF);
      write_reg(CSR_LAST_TIME, 0);
      write_reg(CSR_SEND_ENABLE, 1);
      write_reg(CSR_CLEAR_ENABLE, 1);
      write_reg(CSR_RECEIVE_WAIT, 1);
      csr_bus.valid = 1'b0;
      while (sched_next_run != TIME_MAX) begin
         send_tick(rand_time(), $urandom_range(0, 1), 1, $urandom_range(0, 1));
      end
      repeat (12) begin
         send_tick(($urandom_range(0, 1) != 0) ? TIME_MAX : rand_time(), 0,
                   $urandom_range(0, 2) == 0, $urandom_range(0, 1));
      end
   endtask

   // Receiver: hold ready on a pattern that is redrawn at random.
   initial begin
      rsp_pattern_type pattern;
      int unsigned     pattern_left;
      int unsigned     pulse_len;
      int unsigned     pulse_count;
      pattern      = RSP_FLOW;
      pattern_left = 0;
      pulse_len    = 1;
      pulse_count  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (pattern_left == 0) begin
            pattern      = rsp_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 200);
            pulse_len    = $urandom_range(2, 8);
         end
         pattern_left--;
         pulse_count++;
         case (pattern)
            RSP_FLOW:   rsp_bus.ready = 1'b1;
            RSP_COIN:   rsp_bus.ready = $urandom_range(0, 1);
            RSP_SPARSE: rsp_bus.ready = ($urandom_range(0, 3) == 0);
            default:    rsp_bus.ready = (pulse_count % pulse_len == 0);
         endcase
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_actions.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no tick waiting", results_seen));
         end else begin
            want = pending_actions.pop_front();
            check_field("do_send", rsp_bus.do_send, want.do_send);
            check_field("do_clear", rsp_bus.do_clear, want.do_clear);
            check_field("do_receive", rsp_bus.do_receive, want.do_receive);
            check_field("keep_going", rsp_bus.keep_going, want.keep_going);
         end
         results_seen++;
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int unsigned phase_no;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.time_now       = '0;
      req_bus.srq_pending    = 1'b0;
      req_bus.srq_request    = 1'b0;
      req_bus.data_available = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = '0;
      csr_bus.data           = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_opening();
      test_special_cases();
      // Mostly orderly timelines, every fifth phase noise with modest periods.
      phase_no = 0;
      while (ticks_sent < TICK_TARGET) begin
         if (phase_no % 5 == 4) begin
            test_noise(40, 1'b0);
         end else begin
            test_timeline($urandom_range(20, 70));
         end
         phase_no++;
      end
      // Full-range periods and the saturated run time can only come last.
      test_noise(60, 1'b1);
      test_run_time_saturation();

      req_bus.valid = 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/pqs_pkg.sv
hdl/pqs_if.sv
hdl/pqs_csr.sv
hdl/pqs_core.sv
hdl/pqs_out.sv
hdl/periodic_query_scheduler_unit.sv
tb/sv/periodic_query_scheduler_unit_test.sv
